// ----- rtl/core/cborhe_pkg.sv -----
package cborhe_pkg;

  localparam int CFG_W = 24;
  localparam int CNT_W = 25;
  localparam logic [CFG_W-1:0] MAX_BODY_RESET = 24'd4194304;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // token kinds
  localparam logic [3:0] KIND_NULL  = 4'd0;
  localparam logic [3:0] KIND_BOOL  = 4'd1;
  localparam logic [3:0] KIND_F64   = 4'd2;
  localparam logic [3:0] KIND_SINT  = 4'd3;
  localparam logic [3:0] KIND_UINT  = 4'd4;
  localparam logic [3:0] KIND_TEXT  = 4'd5;
  localparam logic [3:0] KIND_TBYTE = 4'd6;
  localparam logic [3:0] KIND_ARRAY = 4'd7;
  localparam logic [3:0] KIND_MAP   = 4'd8;
  localparam logic [3:0] KIND_BODY  = 4'd9;

  // simple values
  localparam logic [7:0] HEAD_NULL  = 8'hf6;
  localparam logic [7:0] HEAD_TRUE  = 8'hf5;
  localparam logic [7:0] HEAD_FALSE = 8'hf4;
  localparam logic [7:0] HEAD_F64   = 8'hfb;

  // major types
  localparam logic [2:0] MT_UINT  = 3'd0;
  localparam logic [2:0] MT_NINT  = 3'd1;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;

  // additional info for multi-byte arguments
  localparam logic [4:0] AI_ARG1 = 5'd24;
  localparam logic [4:0] AI_ARG2 = 5'd25;
  localparam logic [4:0] AI_ARG4 = 5'd26;
  localparam logic [4:0] AI_ARG8 = 5'd27;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // classified token: head byte plus argument bytes left aligned
  typedef struct packed {
    logic        clr;
    logic [7:0]  head;
    logic [63:0] arg;
    logic [3:0]  nb;
  } tok_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] rem;
  } back_stat_t;

endpackage

// ----- rtl/core/cborhe_front.sv -----
module cborhe_front (
  input  logic              in_valid,
  input  logic [3:0]        in_kind,
  input  logic [63:0]       in_value,
  input  logic              q_full,
  output logic              in_stall,
  output logic              q_push,
  output cborhe_pkg::tok_t  q_tok
);
  import cborhe_pkg::*;

  logic        is_head;
  logic [2:0]  mt;
  logic [63:0] n;
  logic        known;

  assign in_stall = q_full;

  always_comb begin
    is_head = 1'b0;
    mt      = MT_UINT;
    n       = in_value;
    known   = 1'b1;
    q_tok   = '0;
    unique case (in_kind)
      KIND_NULL:  q_tok.head = HEAD_NULL;
      KIND_BOOL:  q_tok.head = in_value[0] ? HEAD_TRUE : HEAD_FALSE;
      KIND_F64: begin
        q_tok.head = HEAD_F64;
        q_tok.arg  = in_value;
        q_tok.nb   = 4'd8;
      end
      KIND_SINT: begin
        is_head = 1'b1;
        if (in_value[63]) begin
          mt = MT_NINT;
          n  = ~in_value;
        end
      end
      KIND_UINT:  is_head = 1'b1;
      KIND_TEXT: begin
        is_head = 1'b1;
        mt      = MT_TEXT;
      end
      KIND_TBYTE: q_tok.head = in_value[7:0];
      KIND_ARRAY: begin
        is_head = 1'b1;
        mt      = MT_ARRAY;
      end
      KIND_MAP: begin
        is_head = 1'b1;
        mt      = MT_MAP;
      end
      KIND_BODY:  q_tok.clr = 1'b1;
      default:    known = 1'b0;
    endcase

    // shortest head, immediate argument only below 24
    if (is_head) begin
      priority if (n < 64'd24) begin
        q_tok.head = {mt, n[4:0]};
      end else if (n[63:8] == '0) begin
        q_tok.head = {mt, AI_ARG1};
        q_tok.arg  = {n[7:0], 56'd0};
        q_tok.nb   = 4'd1;
      end else if (n[63:16] == '0) begin
        q_tok.head = {mt, AI_ARG2};
        q_tok.arg  = {n[15:0], 48'd0};
        q_tok.nb   = 4'd2;
      end else if (n[63:32] == '0) begin
        q_tok.head = {mt, AI_ARG4};
        q_tok.arg  = {n[31:0], 32'd0};
        q_tok.nb   = 4'd4;
      end else begin
        q_tok.head = {mt, AI_ARG8};
        q_tok.arg  = n;
        q_tok.nb   = 4'd8;
      end
    end
  end

  // unused kinds are dropped here
  assign q_push = in_valid && !q_full && known;

endmodule

// ----- rtl/core/cborhe_queue.sv -----
module cborhe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cborhe_pkg::tok_t  push_tok,
  input  logic              pop,
  output logic              full,
  output logic              q_valid,
  output cborhe_pkg::tok_t  q_tok
);
  import cborhe_pkg::*;

  tok_t              mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ----- rtl/core/cborhe_back.sv -----
module cborhe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cborhe_pkg::tok_t              q_tok,
  input  logic [cborhe_pkg::CFG_W-1:0]  max_body,
  input  logic                          out_stall,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  output logic                          out_too_large,
  output cborhe_pkg::back_stat_t        stat
);
  import cborhe_pkg::*;

  logic              busy_r, busy_nxt;
  logic [3:0]        rem_r, rem_nxt;
  logic [71:0]       sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic              flag_r, flag_nxt, flag_inc;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_too_large_r;
  logic              emit, fin;

  assign emit  = busy_r && (!out_valid_r || !out_stall);
  assign fin   = emit && (rem_r == 4'd1);
  // next token is taken in the cycle the current one sends its last byte
  assign q_pop = q_valid && (!busy_r || fin);

  assign cnt_inc  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign flag_inc = flag_r || (cnt_inc > {1'b0, max_body});

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    flag_nxt = flag_r;
    if (emit) begin
      sh_nxt   = {sh_r[63:0], 8'd0};
      rem_nxt  = rem_r - 1'b1;
      cnt_nxt  = cnt_inc;
      flag_nxt = flag_inc;
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      if (q_tok.clr) begin
        // begin body: new count starts after any byte sent this cycle
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
        flag_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        rem_nxt  = q_tok.nb + 1'b1;
        sh_nxt   = {q_tok.head, q_tok.arg};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rem_r       <= '0;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      flag_r <= flag_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
    if (emit) begin
      out_byte_r      <= sh_r[71:64];
      out_last_r      <= (rem_r == 4'd1);
      out_too_large_r <= flag_inc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_too_large = out_too_large_r;
  assign stat.busy     = busy_r;
  assign stat.rem      = rem_r;

endmodule

// ----- rtl/core/cbor_item_head_encoder_top.sv -----
// cbor token stream to byte stream encoder
// input channel: in_valid/in_stall with in_kind and in_value, one token per request
// output channel: out_valid/out_stall with out_byte, out_last and out_too_large,
//   one encoded byte per request, out_last marks the final byte of a token
// config channel: cfg_valid/cfg_ready with cfg_data (max body bytes), always ready,
//   write only while the encoder is idle
// the queue feeds the serializer shift register, which feeds the output register
// throughput: the back-end serializer sends one byte per cycle unless stalled, so a
//   token of 1 to 9 bytes holds it until its last byte is sent; a begin-body token
//   sends no byte, and unused kinds are dropped at the input without using it
// a two-entry token queue sits between the classifier and the serializer; the
//   input keeps taking tokens until that queue is full
// when the receiver stalls, the output register holds its byte and the serializer
//   waits; in_stall rises once the queue fills
// reset clears the queue, the byte counter and the too-large flag, and loads
//   the max body limit with its default of 4194304
module cbor_item_head_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_kind,
  input  logic [63:0]                   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  output logic                          out_too_large,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cborhe_pkg::CFG_W-1:0]  cfg_data
);
  import cborhe_pkg::*;

  logic [CFG_W-1:0] max_body_r;
  logic             q_full, q_push, q_pop, q_valid;
  tok_t             push_tok, q_tok;
  back_stat_t       stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_body_r <= cfg_data;
    end
  end

  cborhe_front u_front (
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_value (in_value),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_tok    (push_tok)
  );

  cborhe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .pop      (q_pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  cborhe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_tok         (q_tok),
    .max_body      (max_body_r),
    .out_stall     (out_stall),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_too_large (out_too_large),
    .stat          (stat)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("token pushed into a full queue");

  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> (stat.rem != 4'd0 && stat.rem <= 4'd9))
    else $error("serializer busy with bad byte count");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && stat.busy) |-> (stat.rem == 4'd1 && (!out_valid || !out_stall)))
    else $error("token popped while serializer still has bytes");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !stat.busy))
    else $error("output not idle after reset");
`endif

endmodule
